// ===== src/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ffa_pkg.sv =====
// Shared types and fixed constants of the first-fit allocator.
// No dependencies; used by every module of the block except ffa_ram.
package ffa_pkg;

  localparam int ADDR_W   = 16;
  localparam int REQ_W    = 17;
  localparam int SIZE_W   = 18;
  localparam int GRAIN_SH = 4;
  localparam int GRAIN    = 16;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_GE  = 1'b1
  } alu_op_t;

  typedef struct packed {
    cmd_t              command;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] free_address;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] block_address;
    logic [REQ_W-1:0]  granted_size;
    logic              reused;
  } out_word_t;

endpackage

// ===== src/ffa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== src/ffa_alu.sv =====
// Shared adder of the allocator: plain add, or unsigned a >= b via the carry.
// Depends on ffa_pkg for the operation code.
module ffa_alu #(
  parameter int W = 8
) (
  input  ffa_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             carry
);

  logic [W-1:0] b_eff;
  logic [W:0]   total;
  logic         sub;

  assign sub   = (op == ffa_pkg::ALU_GE);
  assign b_eff = sub ? ~b : b;
  // With the operand inverted and a carry in, the carry out is set when a >= b.
  assign total = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};
  assign res   = total[W-1:0];
  assign carry = total[W];

endmodule

// ===== src/ffa_seq.sv =====
// Sequencer of the allocator: clear pass, free-list walk, bump and free paths.
// Depends on ffa_pkg; drives the header RAMs and the shared ffa_alu.
module ffa_seq #(
  parameter int HEAP_BYTES = 65536,
  parameter int SLOTS      = 4096,
  parameter int SLOT_W     = 12,
  parameter int LINK_W     = 13,
  parameter int BUMP_W     = 17,
  parameter int ALU_W      = 19
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ffa_pkg::in_word_t          in_data,
  output logic                       res_valid,
  output ffa_pkg::out_word_t         res_data,
  input  logic                       res_taken,
  output logic                       size_we,
  output logic [SLOT_W-1:0]          size_waddr,
  output logic [ffa_pkg::SIZE_W-1:0] size_wdata,
  output logic [SLOT_W-1:0]          size_raddr,
  input  logic [ffa_pkg::SIZE_W-1:0] size_rdata,
  output logic                       link_we,
  output logic [SLOT_W-1:0]          link_waddr,
  output logic [LINK_W-1:0]          link_wdata,
  output logic [SLOT_W-1:0]          link_raddr,
  input  logic [LINK_W-1:0]          link_rdata,
  output logic                       mark_we,
  output logic [SLOT_W-1:0]          mark_waddr,
  output logic                       mark_wdata,
  output logic [SLOT_W-1:0]          mark_raddr,
  input  logic                       mark_rdata,
  output ffa_pkg::alu_op_t           alu_op,
  output logic [ALU_W-1:0]           alu_a,
  output logic [ALU_W-1:0]           alu_b,
  input  logic [ALU_W-1:0]           alu_res,
  input  logic                       alu_carry
);

  localparam logic [LINK_W-1:0] LINK_NULL = {LINK_W{1'b1}};
  localparam logic [LINK_W-1:0] SLOTS_L   = LINK_W'(SLOTS);

  typedef enum logic [9:0] {
    S_CLEAR     = 10'b00_0000_0001,
    S_IDLE      = 10'b00_0000_0010,
    S_WALK      = 10'b00_0000_0100,
    S_TEST      = 10'b00_0000_1000,
    S_UNLINK    = 10'b00_0001_0000,
    S_BUMP_ADD  = 10'b00_0010_0000,
    S_BUMP_CHK  = 10'b00_0100_0000,
    S_FREE_CHK  = 10'b00_1000_0000,
    S_FREE_TEST = 10'b01_0000_0000,
    S_DONE      = 10'b10_0000_0000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ffa_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [ffa_pkg::SIZE_W-1:0] needed_r, needed_nxt;
  logic [ffa_pkg::ADDR_W-1:0] faddr_r, faddr_nxt;
  logic [LINK_W-1:0]          cur_r, cur_nxt;
  logic [LINK_W-1:0]          prev_r, prev_nxt;
  logic [LINK_W-1:0]          steps_r, steps_nxt;
  logic [LINK_W-1:0]          clr_r, clr_nxt;
  logic [LINK_W-1:0]          head_r, head_nxt;
  logic [BUMP_W-1:0]          bump_r, bump_nxt;
  logic [ALU_W-1:0]           sum_r, sum_nxt;
  ffa_pkg::out_word_t         res_r, res_nxt;

  logic [ffa_pkg::SIZE_W-1:0] req_ext;
  logic [ffa_pkg::SIZE_W-1:0] req_round;
  logic [11:0]                free_gran;
  logic                       free_bad;
  logic [SLOT_W-1:0]          cur_idx;
  logic [SLOT_W-1:0]          prev_idx;
  logic [SLOT_W-1:0]          bump_idx;
  logic [SLOT_W-1:0]          free_idx;

  assign cur_idx  = cur_r[SLOT_W-1:0];
  assign prev_idx = prev_r[SLOT_W-1:0];
  assign bump_idx = SLOT_W'(bump_r >> ffa_pkg::GRAIN_SH);

  // Zero counts as one byte, then round up to the granule.
  assign req_ext   = (in_data.request_size == '0) ? ffa_pkg::SIZE_W'(1)
                                                  : ffa_pkg::SIZE_W'(in_data.request_size);
  assign req_round = (req_ext + ffa_pkg::SIZE_W'(ffa_pkg::GRAIN - 1))
                     & ~ffa_pkg::SIZE_W'(ffa_pkg::GRAIN - 1);

  // A user pointer sits one granule past its header.
  assign free_gran = faddr_r[ffa_pkg::ADDR_W-1:ffa_pkg::GRAIN_SH] - 12'd1;
  assign free_idx  = SLOT_W'(free_gran);
  assign free_bad  = (faddr_r[ffa_pkg::ADDR_W-1:ffa_pkg::GRAIN_SH] == '0)
                     || (faddr_r[ffa_pkg::GRAIN_SH-1:0] != '0)
                     || (32'(free_gran) >= 32'(SLOTS));

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  always_comb begin
    state_nxt  = state_r;
    size_nxt   = size_r;
    needed_nxt = needed_r;
    faddr_nxt  = faddr_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    steps_nxt  = steps_r;
    clr_nxt    = clr_r;
    head_nxt   = head_r;
    bump_nxt   = bump_r;
    sum_nxt    = sum_r;
    res_nxt    = res_r;

    size_we    = 1'b0;
    size_waddr = bump_idx;
    size_wdata = size_r;
    size_raddr = cur_idx;
    link_we    = 1'b0;
    link_waddr = cur_idx;
    link_wdata = LINK_NULL;
    link_raddr = cur_idx;
    mark_we    = 1'b0;
    mark_waddr = cur_idx;
    mark_wdata = 1'b1;
    mark_raddr = free_idx;
    alu_op     = ffa_pkg::ALU_GE;
    alu_a      = ALU_W'(size_rdata);
    alu_b      = ALU_W'(size_r);

    unique case (state_r)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_r[SLOT_W-1:0];
        mark_wdata = 1'b0;
        clr_nxt    = clr_r + LINK_W'(1);
        if (clr_r == SLOTS_L - LINK_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          size_nxt   = req_round;
          needed_nxt = req_round + ffa_pkg::SIZE_W'(ffa_pkg::GRAIN);
          faddr_nxt  = in_data.free_address;
          cur_nxt    = head_r;
          prev_nxt   = LINK_NULL;
          steps_nxt  = '0;
          state_nxt  = (in_data.command == ffa_pkg::CMD_FREE) ? S_FREE_CHK : S_WALK;
        end
      end
      S_WALK: begin
        // The address was set by default; header data shows up in S_TEST.
        if (cur_r >= SLOTS_L || steps_r >= SLOTS_L) begin
          state_nxt = S_BUMP_ADD;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (alu_carry) begin
          if (prev_r == LINK_NULL) begin
            head_nxt = link_rdata;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_idx;
            link_wdata = link_rdata;
          end
          mark_we  = 1'b1;
          res_nxt.status        = ffa_pkg::ST_OK;
          res_nxt.block_address = ffa_pkg::ADDR_W'((32'(cur_r) + 32'd1) << ffa_pkg::GRAIN_SH);
          res_nxt.granted_size  = size_rdata[ffa_pkg::REQ_W-1:0];
          res_nxt.reused        = 1'b1;
          state_nxt = S_UNLINK;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rdata;
          steps_nxt = steps_r + LINK_W'(1);
          state_nxt = S_WALK;
        end
      end
      S_UNLINK: begin
        link_we   = 1'b1;
        state_nxt = S_DONE;
      end
      S_BUMP_ADD: begin
        alu_op    = ffa_pkg::ALU_ADD;
        alu_a     = ALU_W'(bump_r);
        alu_b     = ALU_W'(needed_r);
        sum_nxt   = alu_res;
        state_nxt = S_BUMP_CHK;
      end
      S_BUMP_CHK: begin
        alu_a = ALU_W'(HEAP_BYTES);
        alu_b = sum_r;
        if (alu_carry) begin
          size_we    = 1'b1;
          link_we    = 1'b1;
          link_waddr = bump_idx;
          mark_we    = 1'b1;
          mark_waddr = bump_idx;
          bump_nxt   = BUMP_W'(sum_r);
          res_nxt.status        = ffa_pkg::ST_OK;
          res_nxt.block_address = ffa_pkg::ADDR_W'(32'(bump_r) + 32'(ffa_pkg::GRAIN));
          res_nxt.granted_size  = size_r[ffa_pkg::REQ_W-1:0];
          res_nxt.reused        = 1'b0;
        end else begin
          res_nxt = '{status: ffa_pkg::ST_NOSPACE, block_address: '0,
                      granted_size: '0, reused: 1'b0};
        end
        state_nxt = S_DONE;
      end
      S_FREE_CHK: begin
        if (free_bad) begin
          res_nxt   = '{status: ffa_pkg::ST_BADFREE, block_address: '0,
                        granted_size: '0, reused: 1'b0};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FREE_TEST;
        end
      end
      S_FREE_TEST: begin
        if (mark_rdata) begin
          mark_we    = 1'b1;
          mark_waddr = free_idx;
          mark_wdata = 1'b0;
          link_we    = 1'b1;
          link_waddr = free_idx;
          link_wdata = head_r;
          head_nxt   = LINK_W'(free_idx);
          res_nxt    = '{status: ffa_pkg::ST_OK, block_address: '0,
                         granted_size: '0, reused: 1'b0};
        end else begin
          res_nxt    = '{status: ffa_pkg::ST_BADFREE, block_address: '0,
                         granted_size: '0, reused: 1'b0};
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      head_r  <= LINK_NULL;
      bump_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      head_r  <= head_nxt;
      bump_r  <= bump_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r   <= size_nxt;
    needed_r <= needed_nxt;
    faddr_r  <= faddr_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    steps_r  <= steps_nxt;
    sum_r    <= sum_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ===== src/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list heap allocator with bump pointer.
// Depends on ffa_pkg, ffa_ram, ffa_alu, ffa_seq and assert_macros.svh.
//
// Usage: each word on the in_ channel is one command. An allocate word asks
// for request_size bytes; the size is rounded up to 16 (zero counts as 16),
// the free list is walked first-fit from its head and the first block that
// is large enough is handed out whole. With no fit, a header plus body is
// carved at the bump pointer, or out of space is reported. A free word
// pushes the block on the list head if it is marked allocated, otherwise it
// is reported as a bad free and ignored. Every command yields one word on
// the out_ channel.
// Timing: the block takes one command at a time. An allocate visits S_WALK
// and S_TEST for each block on the free list up to the fit, then S_UNLINK
// when it reuses a block, or S_BUMP_ADD and S_BUMP_CHK when it bumps; a
// free passes S_FREE_CHK and S_FREE_TEST, only S_FREE_CHK when the pointer
// is malformed. The walk is paced by the header RAM's registered read.
// Reset: after rst_n the allocated marks are cleared one granule per cycle,
// and in_ready stays low until that pass is done.
// Stalls: the result sits in an output register; a new command is accepted
// while it waits, and that command's result holds until the register frees.
`include "assert_macros.svh"

module first_fit_free_list_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ffa_pkg::out_word_t out_data
);

  // Granule count and the widths that follow from it. Links carry one
  // extra bit so that the all-ones null link lies outside the heap.
  localparam int SLOTS  = HEAP_BYTES / ffa_pkg::GRAIN;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LINK_W = SLOT_W + 1;
  localparam int BUMP_W = $clog2(HEAP_BYTES + 1);
  localparam int ALU_W  = ((BUMP_W > ffa_pkg::SIZE_W) ? BUMP_W : ffa_pkg::SIZE_W) + 1;

  logic                       res_valid;
  ffa_pkg::out_word_t         res_data;
  logic                       res_taken;

  logic                       size_we, link_we, mark_we;
  logic [SLOT_W-1:0]          size_waddr, size_raddr;
  logic [SLOT_W-1:0]          link_waddr, link_raddr;
  logic [SLOT_W-1:0]          mark_waddr, mark_raddr;
  logic [ffa_pkg::SIZE_W-1:0] size_wdata, size_rdata;
  logic [LINK_W-1:0]          link_wdata, link_rdata;
  logic                       mark_wdata, mark_rdata;

  ffa_pkg::alu_op_t           alu_op;
  logic [ALU_W-1:0]           alu_a, alu_b, alu_res;
  logic                       alu_carry;

  logic                       out_valid_r, out_valid_nxt;
  ffa_pkg::out_word_t         out_data_r, out_data_nxt;

  // Header fields live in three granule-indexed RAMs: body size, next link
  // and the allocated mark.
  ffa_ram #(.WIDTH(ffa_pkg::SIZE_W), .DEPTH(SLOTS)) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (size_raddr),
    .rdata (size_rdata)
  );

  ffa_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  ffa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  // One adder serves the fit test, the bump sum and the heap-limit test.
  ffa_alu #(.W(ALU_W)) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  ffa_seq #(
    .HEAP_BYTES (HEAP_BYTES),
    .SLOTS      (SLOTS),
    .SLOT_W     (SLOT_W),
    .LINK_W     (LINK_W),
    .BUMP_W     (BUMP_W),
    .ALU_W      (ALU_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_taken  (res_taken),
    .size_we    (size_we),
    .size_waddr (size_waddr),
    .size_wdata (size_wdata),
    .size_raddr (size_raddr),
    .size_rdata (size_rdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .mark_we    (mark_we),
    .mark_waddr (mark_waddr),
    .mark_wdata (mark_wdata),
    .mark_raddr (mark_raddr),
    .mark_rdata (mark_rdata),
    .alu_op     (alu_op),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_res    (alu_res),
    .alu_carry  (alu_carry)
  );

  // The output register takes a finished result whenever it is empty or
  // being drained in the same cycle.
  assign res_taken = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_taken) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Once a command is taken the sequencer is busy until its result is out.
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // A finished result waits in the sequencer while the output register is full.
  `ASSERT_NEXT(a_result_holds, res_valid && !res_taken, res_valid && $stable(res_data))
  // Only a successful allocate carries an address, a size or the reuse flag.
  `ASSERT_NOW(a_fields_zero_unless_grant,
              out_valid && (out_data.status != ffa_pkg::ST_OK || out_data.block_address == '0),
              out_data.granted_size == '0 && !out_data.reused)

endmodule
